FILE: rtl/core/vfcao_pkg.sv
// ----------------------------------------------------------------------------
// vfcao_pkg
// Shared types, tables and helpers for voxel face culling with per-corner
// ambient occlusion.
// ----------------------------------------------------------------------------
package vfcao_pkg;

	localparam int FaceCount = 6;
	localparam int PosW      = 6;
	localparam int TexW      = 9;
	localparam int AoW       = 2;
	localparam int OccW      = 27;
	localparam int WordW     = 40;

	// Orientation codes as they appear in the face word
	typedef enum logic [2:0] {
		ORI_TOP    = 3'd0,
		ORI_BOTTOM = 3'd1,
		ORI_FRONT  = 3'd2,
		ORI_BACK   = 3'd3,
		ORI_LEFT   = 3'd4,
		ORI_RIGHT  = 3'd5
	} ori_t;

	// Faces leave in this order: front, back, bottom, top, left, right
	localparam ori_t EMIT_ORDER [0:FaceCount-1] = '{
		ORI_FRONT, ORI_BACK, ORI_BOTTOM, ORI_TOP, ORI_LEFT, ORI_RIGHT
	};

	// Occluder bit per orientation:
	// side lx, side hx, side ly, side hy, corner lxly, hxly, lxhy, hxhy
	localparam logic [4:0] NB_BITS [0:FaceCount-1][0:7] = '{
		'{5'd15, 5'd17, 5'd7,  5'd25, 5'd6,  5'd8,  5'd24, 5'd26},
		'{5'd9,  5'd11, 5'd1,  5'd19, 5'd0,  5'd2,  5'd18, 5'd20},
		'{5'd3,  5'd5,  5'd1,  5'd7,  5'd0,  5'd2,  5'd6,  5'd8 },
		'{5'd21, 5'd23, 5'd19, 5'd25, 5'd18, 5'd20, 5'd24, 5'd26},
		'{5'd9,  5'd15, 5'd3,  5'd21, 5'd0,  5'd6,  5'd18, 5'd24},
		'{5'd5,  5'd23, 5'd11, 5'd17, 5'd2,  5'd20, 5'd8,  5'd26}
	};

	// Selected face handed from the face mux to the result register
	typedef struct packed {
		logic             any;
		logic             last;
		logic [WordW-1:0] word;
	} pick_t;

	// Corner AO: zero when both sides occlude, else 3 minus occluder count
	function automatic logic [AoW-1:0] corner_ao(input logic s1, input logic s2,
		input logic c);
		logic [AoW-1:0] cnt;
		cnt = {1'b0, s1} + {1'b0, s2} + {1'b0, c};
		if (s1 && s2) begin
			return '0;
		end
		return 2'd3 - cnt;
	endfunction

endpackage

FILE: rtl/core/voxel_face_cull_ao_top.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_ao_top
// Voxel face culling with per-corner ambient occlusion: one voxel in, one
// packed face word out for each visible face.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------------
//   voxel   | vox_valid, vox_stall   | pos_x/y/z, is_air, self_liquid, face_*, occluders
//   face    | face_valid, face_stall | face_word, last_face
//
// A voxel sends one face per cycle through the single face output register while
// face_stall is low; air voxels and voxels with no visible face send no face.
// A new voxel is taken in the cycle its predecessor sends its last face.
// Results appear the cycle after the face is picked from the voxel register.
// Reset clears the pending-face mask and the result valid; no clearing pass.
// face_stall holds the result register and, through it, the voxel register.
// ----------------------------------------------------------------------------
module voxel_face_cull_ao_top (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       vox_valid,
	output logic                                       vox_stall,
	input  logic [vfcao_pkg::PosW-1:0]                 pos_x,
	input  logic [vfcao_pkg::PosW-1:0]                 pos_y,
	input  logic [vfcao_pkg::PosW-1:0]                 pos_z,
	input  logic                                       is_air,
	input  logic                                       self_liquid,
	input  logic [vfcao_pkg::FaceCount-1:0]            face_open,
	input  logic [vfcao_pkg::FaceCount-1:0]            face_liquid,
	input  logic [vfcao_pkg::OccW-1:0]                 occluders,
	input  logic [vfcao_pkg::FaceCount*vfcao_pkg::TexW-1:0] face_textures,
	output logic                                       face_valid,
	input  logic                                       face_stall,
	output logic [vfcao_pkg::WordW-1:0]                face_word,
	output logic                                       last_face
);

	logic [vfcao_pkg::PosW-1:0]      pos_x_s1, pos_y_s1, pos_z_s1;
	logic [vfcao_pkg::OccW-1:0]      occ_s1;
	logic [vfcao_pkg::FaceCount*vfcao_pkg::TexW-1:0] tex_s1;
	logic [vfcao_pkg::FaceCount-1:0] mask_s1;
	logic [vfcao_pkg::FaceCount-1:0] vis_new;
	logic [vfcao_pkg::FaceCount-1:0] first;
	logic [vfcao_pkg::WordW-1:0]     word_q;
	logic                            last_q;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            advance;
	logic                            vox_take;
	vfcao_pkg::pick_t                pick;

	// Visible faces of the incoming voxel, in emission order
	always_comb begin
		for (int i = 0; i < vfcao_pkg::FaceCount; i++) begin
			vis_new[i] = !is_air &&
				(face_open[vfcao_pkg::EMIT_ORDER[i]] ||
				 (!self_liquid && face_liquid[vfcao_pkg::EMIT_ORDER[i]]));
		end
	end

	// Handshake: advance one face whenever the result register can take it
	assign out_free  = !out_valid_q || !face_stall;
	assign advance   = out_free && pick.any;
	assign vox_stall = pick.any && !(advance && pick.last);
	assign vox_take  = vox_valid && !vox_stall;
	assign first     = mask_s1 & (~mask_s1 + vfcao_pkg::FaceCount'(1));

	// Hold the voxel payload for the whole transaction
	always_ff @(posedge clk) begin
		if (vox_take) begin
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			pos_z_s1 <= pos_z;
			occ_s1   <= occluders;
			tex_s1   <= face_textures;
		end
	end

	// Pending-face mask: load on accept, drop the emitted face on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (vox_take) begin
			mask_s1 <= vis_new;
		end else if (advance) begin
			mask_s1 <= mask_s1 & ~first;
		end
	end

	vfcao_face_mux u_face_mux (
		.pos_x         (pos_x_s1),
		.pos_y         (pos_y_s1),
		.pos_z         (pos_z_s1),
		.occluders     (occ_s1),
		.face_textures (tex_s1),
		.pending       (mask_s1),
		.pick          (pick)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= pick.word;
			last_q <= pick.last;
		end
	end

	assign face_valid = out_valid_q;
	assign face_word  = word_q;
	assign last_face  = last_q;

	// A face taken from the voxel register shows up as a result next cycle
	a_adv_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> face_valid)
		else $error("picked face did not reach the result register");

	// A non-final face leaves while the voxel still has faces pending
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(face_valid && !face_stall && !last_face) |-> (mask_s1 != '0))
		else $error("face sent without last mark but no faces remain");

	// Voxel side only stalls while a voxel is held
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vox_stall |-> (mask_s1 != '0))
		else $error("voxel channel stalled with an empty voxel register");

	// The final face of a voxel empties the pending mask unless a new voxel loads
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pick.last && !vox_valid) |=> (mask_s1 == '0))
		else $error("pending faces left after the last face was sent");

endmodule

FILE: rtl/core/vfcao_face_mux.sv
// ----------------------------------------------------------------------------
// vfcao_face_mux
// Builds the packed word of every face of the held voxel and picks the first
// pending one in emission order.
// ----------------------------------------------------------------------------
module vfcao_face_mux (
	input  logic [vfcao_pkg::PosW-1:0]             pos_x,
	input  logic [vfcao_pkg::PosW-1:0]             pos_y,
	input  logic [vfcao_pkg::PosW-1:0]             pos_z,
	input  logic [vfcao_pkg::OccW-1:0]             occluders,
	input  logic [vfcao_pkg::FaceCount*vfcao_pkg::TexW-1:0] face_textures,
	input  logic [vfcao_pkg::FaceCount-1:0]        pending,
	output vfcao_pkg::pick_t                       pick
);

	logic [vfcao_pkg::WordW-1:0]     words [0:vfcao_pkg::FaceCount-1];
	logic [vfcao_pkg::FaceCount-1:0] first;
	logic [vfcao_pkg::WordW-1:0]     word_mux;

	// Build one word per emission slot
	for (genvar i = 0; i < vfcao_pkg::FaceCount; i++) begin : g_face
		localparam int K = int'(vfcao_pkg::EMIT_ORDER[i]);
		logic lx, hx, ly, hy;
		logic [vfcao_pkg::AoW-1:0] a00, a10, a11, a01;

		assign lx  = occluders[vfcao_pkg::NB_BITS[K][0]];
		assign hx  = occluders[vfcao_pkg::NB_BITS[K][1]];
		assign ly  = occluders[vfcao_pkg::NB_BITS[K][2]];
		assign hy  = occluders[vfcao_pkg::NB_BITS[K][3]];
		assign a00 = vfcao_pkg::corner_ao(lx, ly, occluders[vfcao_pkg::NB_BITS[K][4]]);
		assign a10 = vfcao_pkg::corner_ao(hx, ly, occluders[vfcao_pkg::NB_BITS[K][5]]);
		assign a01 = vfcao_pkg::corner_ao(lx, hy, occluders[vfcao_pkg::NB_BITS[K][6]]);
		assign a11 = vfcao_pkg::corner_ao(hx, hy, occluders[vfcao_pkg::NB_BITS[K][7]]);

		assign words[i] = {a01, a11, a10, a00, 2'b00,
			face_textures[K*vfcao_pkg::TexW +: vfcao_pkg::TexW],
			vfcao_pkg::EMIT_ORDER[i], pos_z, pos_y, pos_x};
	end

	// Isolate the first pending slot
	assign first = pending & (~pending + vfcao_pkg::FaceCount'(1));

	// AND-OR select of the chosen word
	always_comb begin
		word_mux = '0;
		for (int i = 0; i < vfcao_pkg::FaceCount; i++) begin
			word_mux = word_mux | (words[i] & {vfcao_pkg::WordW{first[i]}});
		end
	end

	assign pick.any  = |pending;
	assign pick.last = (pending & ~first) == '0;
	assign pick.word = word_mux;

endmodule

FILE: verif/voxel_face_cull_ao_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_cull_ao_top_tb
// Sends voxels with their neighborhood flags into voxel_face_cull_ao_top.
// A scoreboard predicts the visible faces and their corner AO values for
// each accepted voxel, then checks every face transaction in arrival order.
// A directed set covers field extremes, air, liquid and culling corners.
// Random voxels follow under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module voxel_face_cull_ao_top_tb;

	localparam int PosW      = vfcao_pkg::PosW;
	localparam int TexW      = vfcao_pkg::TexW;
	localparam int AoW       = vfcao_pkg::AoW;
	localparam int OccW      = vfcao_pkg::OccW;
	localparam int WordW     = vfcao_pkg::WordW;
	localparam int FaceCount = vfcao_pkg::FaceCount;

	localparam int ClkHalf       = 4;
	localparam int ResetCycles   = 12;
	localparam int WatchdogLimit = 4000;
	localparam int TailCycles    = 16;
	localparam int ReportCap     = 30;

	typedef struct {
		logic [PosW-1:0]           x;
		logic [PosW-1:0]           y;
		logic [PosW-1:0]           z;
		logic                      air;
		logic                      liquid;
		logic [FaceCount-1:0]      open;
		logic [FaceCount-1:0]      nb_liquid;
		logic [OccW-1:0]           occ;
		logic [FaceCount*TexW-1:0] tex;
	} voxel_t;

	typedef struct {
		logic [WordW-1:0] word;
		logic             last;
	} face_t;

	// Faces leave front, back, bottom, top, left, right
	localparam vfcao_pkg::ori_t FACE_ORDER [FaceCount] = '{
		vfcao_pkg::ORI_FRONT, vfcao_pkg::ORI_BACK, vfcao_pkg::ORI_BOTTOM,
		vfcao_pkg::ORI_TOP, vfcao_pkg::ORI_LEFT, vfcao_pkg::ORI_RIGHT
	};

	// Neighborhood bit per orientation code:
	// sides lx, hx, ly, hy, then corners lxly, hxly, lxhy, hxhy
	localparam int SHADE_BITS [FaceCount][8] = '{
		'{15, 17,  7, 25,  6,  8, 24, 26},
		'{ 9, 11,  1, 19,  0,  2, 18, 20},
		'{ 3,  5,  1,  7,  0,  2,  6,  8},
		'{21, 23, 19, 25, 18, 20, 24, 26},
		'{ 9, 15,  3, 21,  0,  6, 18, 24},
		'{ 5, 23, 11, 17,  2, 20,  8, 26}
	};

	// Expected face words per voxel, checked in arrival order
	class face_scoreboard;
		face_t pending[$];
		int    errors = 0;

		task report(string msg);
			if (errors < ReportCap)
				$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function logic [AoW-1:0] corner_shade(logic s1, logic s2, logic c);
			logic [AoW-1:0] r;
			r = AoW'(3 - (int'(s1) + int'(s2) + int'(c)));
			if (s1 && s2)
				r = '0;
			return r;
		endfunction

		// Predict the faces of one accepted voxel transaction
		function void note_voxel(voxel_t v);
			logic [FaceCount-1:0] shown;
			logic [7:0]           s;
			logic [AoW-1:0]       a00, a10, a11, a01;
			int                   ko;
			int                   last_i;
			face_t                f;
			last_i = -1;
			for (int i = 0; i < FaceCount; i++) begin
				ko = int'(FACE_ORDER[i]);
				shown[i] = !v.air && (v.open[ko] || (!v.liquid && v.nb_liquid[ko]));
				if (shown[i])
					last_i = i;
			end
			for (int i = 0; i < FaceCount; i++) begin
				if (shown[i]) begin
					ko = int'(FACE_ORDER[i]);
					for (int j = 0; j < 8; j++)
						s[j] = v.occ[SHADE_BITS[ko][j]];
					a00 = corner_shade(s[0], s[2], s[4]);
					a10 = corner_shade(s[1], s[2], s[5]);
					a11 = corner_shade(s[1], s[3], s[7]);
					a01 = corner_shade(s[0], s[3], s[6]);
					f.word = {a01, a11, a10, a00, 2'b00, v.tex[ko*TexW +: TexW],
						FACE_ORDER[i], v.z, v.y, v.x};
					f.last = (i == last_i);
					pending = {pending, f};
				end
			end
		endfunction

		// Compare one face transaction with the oldest expectation
		task check_face(logic [WordW-1:0] word, logic last);
			face_t e;
			if (pending.size() == 0) begin
				report($sformatf("face_word %h arrived with nothing expected", word));
				return;
			end
			e = pending.pop_front();
			if (word !== e.word)
				report($sformatf("face_word %h, expected %h", word, e.word));
			if (last !== e.last)
				report($sformatf("last_face %b, expected %b (face_word %h)",
					last, e.last, e.word));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      vox_valid = 1'b0;
	logic                      vox_stall;
	logic [PosW-1:0]           pos_x = '0;
	logic [PosW-1:0]           pos_y = '0;
	logic [PosW-1:0]           pos_z = '0;
	logic                      is_air = 1'b0;
	logic                      self_liquid = 1'b0;
	logic [FaceCount-1:0]      face_open = '0;
	logic [FaceCount-1:0]      face_liquid = '0;
	logic [OccW-1:0]           occluders = '0;
	logic [FaceCount*TexW-1:0] face_textures = '0;
	logic                      face_valid;
	logic                      face_stall = 1'b0;
	logic [WordW-1:0]          face_word;
	logic                      last_face;

	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int quiet_cycles = 0;

	face_scoreboard faces;

	voxel_face_cull_ao_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.vox_valid     (vox_valid),
		.vox_stall     (vox_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.is_air        (is_air),
		.self_liquid   (self_liquid),
		.face_open     (face_open),
		.face_liquid   (face_liquid),
		.occluders     (occluders),
		.face_textures (face_textures),
		.face_valid    (face_valid),
		.face_stall    (face_stall),
		.face_word     (face_word),
		.last_face     (last_face)
	);

	always begin
		#(ClkHalf) clk = 1'b1;
		#(ClkHalf) clk = 1'b0;
	end

	function automatic voxel_t make_voxel(logic [PosW-1:0] x, logic [PosW-1:0] y,
		logic [PosW-1:0] z, logic air, logic liquid, logic [FaceCount-1:0] open,
		logic [FaceCount-1:0] nb_liquid, logic [OccW-1:0] occ,
		logic [FaceCount*TexW-1:0] tex);
		voxel_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		v.air = air;
		v.liquid = liquid;
		v.open = open;
		v.nb_liquid = nb_liquid;
		v.occ = occ;
		v.tex = tex;
		return v;
	endfunction

	// Stall the face channel at random
	always @(posedge clk) begin
		face_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Note accepted voxels, check faces, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (vox_valid && !vox_stall)
				faces.note_voxel(make_voxel(pos_x, pos_y, pos_z, is_air, self_liquid,
					face_open, face_liquid, occluders, face_textures));
			if (face_valid && !face_stall)
				faces.check_face(face_word, last_face);
			if ((vox_valid && !vox_stall) || (face_valid && !face_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WatchdogLimit) begin
					$display("** voxel_face_cull_ao_top: FAILED **");
					$finish;
				end
			end
		end
	end

	// Offer one voxel, idling first at random; return once it is accepted
	task automatic send_voxel(voxel_t v);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			vox_valid <= 1'b0;
			@(posedge clk);
		end
		vox_valid     <= 1'b1;
		pos_x         <= v.x;
		pos_y         <= v.y;
		pos_z         <= v.z;
		is_air        <= v.air;
		self_liquid   <= v.liquid;
		face_open     <= v.open;
		face_liquid   <= v.nb_liquid;
		occluders     <= v.occ;
		face_textures <= v.tex;
		do @(posedge clk); while (vox_stall);
	endtask

	// Hold the voxel channel until every expected face has come out
	task automatic drain_faces();
		vox_valid <= 1'b0;
		do @(posedge clk); while (faces.pending.size() != 0);
	endtask

	// Random voxels: mostly solid with mixed openness, some air and liquid
	task automatic run_phase(int tx_pct, int rx_pct, int count);
		voxel_t v;
		int     pick;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			v.x = PosW'($urandom_range(0, 63));
			v.y = PosW'($urandom_range(0, 63));
			v.z = PosW'($urandom_range(0, 63));
			v.air = ($urandom_range(0, 99) < 8);
			v.liquid = ($urandom_range(0, 99) < 30);
			if (pick < 15)
				v.open = '0;
			else if (pick < 25)
				v.open = '1;
			else
				v.open = FaceCount'($urandom);
			v.nb_liquid = FaceCount'($urandom);
			if ($urandom_range(0, 1) == 1)
				v.occ = OccW'($urandom);
			else
				v.occ = OccW'($urandom & $urandom);
			v.tex = (FaceCount*TexW)'({$urandom, $urandom});
			send_voxel(v);
		end
	endtask

	initial begin
		faces = new;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, air, hidden voxels, liquid rules
		send_voxel(make_voxel(0, 0, 0, 1'b0, 1'b0, '1, '0, '0, '0));
		send_voxel(make_voxel(63, 63, 63, 1'b0, 1'b0, '1, '1, '1, '1));
		send_voxel(make_voxel(21, 42, 7, 1'b1, 1'b0, '1, '1, '1, '1));
		send_voxel(make_voxel(1, 2, 3, 1'b1, 1'b1, '0, '0, '0, '0));
		send_voxel(make_voxel(10, 20, 30, 1'b0, 1'b0, '0, '0, 27'h5A5A5A5,
			54'h2AAAAAAAAAAAAA));
		send_voxel(make_voxel(5, 5, 5, 1'b0, 1'b1, '0, '1, 27'h3C3C3C3,
			54'h15555555555555));
		send_voxel(make_voxel(6, 6, 6, 1'b0, 1'b0, '0, '1, 27'h0F0F0F0,
			54'h2AAAAAAAAAAAAA));
		send_voxel(make_voxel(7, 7, 7, 1'b0, 1'b1, 6'b010101, '1, 27'h1234567,
			54'h15555555555555));
		send_voxel(make_voxel(8, 9, 10, 1'b0, 1'b1, 6'b101010, 6'b010101, '1, '1));
		for (int k = 0; k < FaceCount; k++)
			send_voxel(make_voxel(PosW'(k), PosW'(63 - k), PosW'(9 * k), 1'b0, 1'b0,
				6'b1 << k, '0, 27'h5A5A5A5 ^ (27'h1FF << (3 * k)),
				54'h2AAAAAAAAAAAAA >> k));
		send_voxel(make_voxel(32, 16, 48, 1'b0, 1'b0, '1, '0, 27'h0002000, '1));
		send_voxel(make_voxel(17, 34, 51, 1'b0, 1'b0, '1, '0, 27'h5555555,
			54'h15555555555555));
		send_voxel(make_voxel(51, 34, 17, 1'b0, 1'b0, '1, '0, 27'h2AAAAAA,
			54'h2AAAAAAAAAAAAA));
		send_voxel(make_voxel(40, 0, 63, 1'b0, 1'b0, '1, '0, 27'h7FFDFFF, '0));

		run_phase(26, 67, 70);
		drain_faces();
		run_phase(67, 26, 70);
		run_phase(0, 0, 71);

		drain_faces();
		repeat (TailCycles) @(posedge clk);
		if (faces.errors == 0)
			$display("** voxel_face_cull_ao_top: PASSED **");
		else
			$display("** voxel_face_cull_ao_top: FAILED **");
		$finish;
	end

endmodule
